// ===== design/button_click_classifier_core_assert.svh =====
// Assertion macros for the button click classifier core.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked while reset is released
`define BCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bcc check failed: same-cycle implication");

// Next-cycle implication, checked while reset is released
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bcc check failed: next-cycle implication");

`endif

// ===== design/bcc_pkg.sv =====
// Shared types and constants of the button click classifier.
// Used by bcc_cfg_regs, bcc_fsm and button_click_classifier_core.
package bcc_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_INV      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DEB    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DEB  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VLONG_PRESS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT = 3'd6;

  // Reset values of the registers
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_MS = 16'd20;
  localparam logic [CFG_DATA_W-1:0] RST_DOUBLE_MS   = 16'd300;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_MS     = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_VLONG_MS    = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] RST_TIMEOUT_MS  = 16'd10000;

  // Event code width and output bus width
  localparam int EV_W       = 3;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_CLICK   = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_LONG    = 3'd3,
    EV_VLONG   = 3'd4,
    EV_TIMEOUT = 3'd5,
    EV_ERROR   = 3'd6
  } event_e;

  // Classifier phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_DEB_PR  = 6'b000010,
    PH_HELD    = 6'b000100,
    PH_DEB_REL = 6'b001000,
    PH_DOUBLE  = 6'b010000,
    PH_TIMEOUT = 6'b100000
  } phase_e;

  // Register file contents handed to the classifier
  typedef struct packed {
    logic                  pin_inv;
    logic [CFG_DATA_W-1:0] press_deb;
    logic [CFG_DATA_W-1:0] release_deb;
    logic [CFG_DATA_W-1:0] double_win;
    logic [CFG_DATA_W-1:0] long_press;
    logic [CFG_DATA_W-1:0] vlong_press;
    logic [CFG_DATA_W-1:0] hold_timeout;
  } cfg_t;

  // Classifier status seen by the top level
  typedef struct packed {
    phase_e phase;
    logic   first_click;
  } fsm_status_t;

endpackage

// ===== design/button_click_classifier_core.sv =====
// Button click classifier: debounce, click, double, long, very long, timeout and error detection.
// Depends on bcc_pkg, bcc_cfg_regs, bcc_fsm and the assertion macro header.
//
// Usage:
//   Input stream s_axis: one request per poll tick, carrying the time in
//   milliseconds and the raw pin level. Output stream m_axis: exactly one
//   event code per accepted tick, in order (0 none, 1 click, 2 double,
//   3 long, 4 very long, 5 timeout, 6 error).
//   Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write one register per
//   cycle; write only while no tick is in flight.
//   Pipeline: two register stages (input register, then classifier logic
//   into the result register); each event passes both registers before
//   m_axis_tvalid rises for it.
//   Throughput: one tick per cycle while m_axis_tready is high; the single
//   pass through the state machine between the two registers sets that figure.
//   Stall: while m_axis_tready is low the result holds, one more tick
//   waits in the input register, then s_axis_tready drops.
//   Reset: registers return to their defaults (level 0 pressed, 20/20/300/
//   1000/3000/10000 ms), the machine waits for a press, both stages empty.
`include "button_click_classifier_core_assert.svh"

module button_click_classifier_core #(
  parameter int  TIME_BITS = 32,
  localparam int InDataW   = ((TIME_BITS + 1 + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Poll tick stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [InDataW-1:0]              s_axis_tdata,  // now_ms, pin_level, zero fill
  // Event stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // click_event, zero fill
);
  import bcc_pkg::*;

  cfg_t                 cfg;
  fsm_status_t          status;
  event_e               ev;

  logic                 in_vld_q, in_vld_d;
  logic [TIME_BITS-1:0] in_now_q;
  logic                 in_level_q;
  logic                 out_vld_q, out_vld_d;
  event_e               out_ev_q;
  logic                 out_ready;
  logic                 in_accept;
  logic                 step;

  // Handshake: result stage frees when empty or taken; input stage follows
  always_comb begin
    out_ready     = !out_vld_q || m_axis_tready;
    s_axis_tready = !in_vld_q || out_ready;
    in_accept     = s_axis_tvalid && s_axis_tready;
    step          = in_vld_q && out_ready;
    in_vld_d      = in_accept || (in_vld_q && !out_ready);
    out_vld_d     = step || (out_vld_q && !m_axis_tready);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_now_q   <= s_axis_tdata[TIME_BITS-1:0];
      in_level_q <= s_axis_tdata[TIME_BITS];
    end
  end

  bcc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bcc_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .now_i    (in_now_q),
    .level_i  (in_level_q),
    .cfg_i    (cfg),
    .ev_o     (ev),
    .status_o (status)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_ev_q <= ev;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - EV_W){1'b0}}, out_ev_q};

  // A processed tick always lands in the result register
  `BCC_ASSERT_NEXT(a_step_to_out, clk_i, rst_ni, step, m_axis_tvalid)

  // Every reported event ends in the wait-for-press phase
  `BCC_ASSERT_NEXT(a_event_to_idle, clk_i, rst_ni, step && (ev != EV_NONE),
                   status.phase == PH_IDLE)

  // Input back-pressure only when both stages are full and stalled
  `BCC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
                  in_vld_q && out_vld_q && !m_axis_tready)

endmodule

// ===== design/bcc_cfg_regs.sv =====
// Configuration register file of the button click classifier.
// Depends on bcc_pkg for register indexes, reset values and cfg_t.
module bcc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bcc_pkg::cfg_t                  cfg_o
);
  import bcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode one register write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIN_INV:      cfg_d.pin_inv      = cfg_data_i[0];
        CFG_PRESS_DEB:    cfg_d.press_deb    = cfg_data_i;
        CFG_RELEASE_DEB:  cfg_d.release_deb  = cfg_data_i;
        CFG_DOUBLE_WIN:   cfg_d.double_win   = cfg_data_i;
        CFG_LONG_PRESS:   cfg_d.long_press   = cfg_data_i;
        CFG_VLONG_PRESS:  cfg_d.vlong_press  = cfg_data_i;
        CFG_HOLD_TIMEOUT: cfg_d.hold_timeout = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_inv      <= 1'b1;
      cfg_q.press_deb    <= RST_DEBOUNCE_MS;
      cfg_q.release_deb  <= RST_DEBOUNCE_MS;
      cfg_q.double_win   <= RST_DOUBLE_MS;
      cfg_q.long_press   <= RST_LONG_MS;
      cfg_q.vlong_press  <= RST_VLONG_MS;
      cfg_q.hold_timeout <= RST_TIMEOUT_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/bcc_fsm.sv =====
// Click classification state machine: phase, press start, last event time.
// Depends on bcc_pkg for phase_e, event_e, cfg_t and fsm_status_t.
module bcc_fsm #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 level_i,
  input  bcc_pkg::cfg_t        cfg_i,
  output bcc_pkg::event_e      ev_o,
  output bcc_pkg::fsm_status_t status_o
);
  import bcc_pkg::*;

  // Compare width covers both elapsed time and twice the hold timeout
  localparam int CmpW = (TIME_BITS > CFG_DATA_W + 1) ? TIME_BITS : CFG_DATA_W + 1;

  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic [TIME_BITS-1:0] last_event_q, last_event_d;
  logic                 first_click_q, first_click_d;
  event_e               ev;

  logic                 pressed;
  logic [TIME_BITS-1:0] d_press, d_last;
  logic [CmpW-1:0]      el_press, el_last;
  logic                 press_deb_gt, release_deb_gt, double_gt;
  logic                 long_gt, vlong_gt, timeout_gt, error_gt;

  // Elapsed times wrap modulo 2^TIME_BITS; all compares are strict
  always_comb begin
    pressed        = level_i ^ cfg_i.pin_inv;
    d_press        = now_i - press_start_q;
    d_last         = now_i - last_event_q;
    el_press       = CmpW'(d_press);
    el_last        = CmpW'(d_last);
    press_deb_gt   = el_press > CmpW'(cfg_i.press_deb);
    release_deb_gt = el_last > CmpW'(cfg_i.release_deb);
    double_gt      = el_last > CmpW'(cfg_i.double_win);
    long_gt        = el_press > CmpW'(cfg_i.long_press);
    vlong_gt       = el_press > CmpW'(cfg_i.vlong_press);
    timeout_gt     = el_press > CmpW'(cfg_i.hold_timeout);
    error_gt       = el_press > CmpW'({cfg_i.hold_timeout, 1'b0});
  end

  // Next state and event for the current tick
  always_comb begin
    phase_d       = phase_q;
    press_start_d = press_start_q;
    last_event_d  = last_event_q;
    first_click_d = first_click_q;
    ev            = EV_NONE;
    unique case (phase_q)
      PH_DEB_PR: begin
        if (press_deb_gt) begin
          phase_d = pressed ? PH_HELD : PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          if (vlong_gt) begin
            phase_d = PH_IDLE;
            ev      = EV_VLONG;
          end else if (long_gt) begin
            phase_d = PH_IDLE;
            ev      = EV_LONG;
          end else begin
            last_event_d = now_i;
            phase_d      = PH_DEB_REL;
          end
        end else if (timeout_gt) begin
          phase_d      = PH_TIMEOUT;
          last_event_d = now_i;
        end
      end
      PH_DEB_REL: begin
        if (release_deb_gt) begin
          phase_d = PH_DOUBLE;
        end
      end
      PH_DOUBLE: begin
        // second press keeps the first press's start time
        if (pressed && !first_click_q) begin
          last_event_d  = now_i;
          first_click_d = 1'b1;
          phase_d       = PH_DEB_PR;
        end else if (double_gt) begin
          phase_d = PH_IDLE;
          if (first_click_q) begin
            first_click_d = 1'b0;
            ev            = EV_DOUBLE;
          end else begin
            ev = EV_CLICK;
          end
        end
      end
      PH_TIMEOUT: begin
        if (!pressed) begin
          if (release_deb_gt) begin
            last_event_d = now_i;
            phase_d      = PH_IDLE;
            ev           = EV_TIMEOUT;
          end
        end else begin
          last_event_d = now_i;
          if (error_gt) begin
            phase_d = PH_IDLE;
            ev      = EV_ERROR;
          end
        end
      end
      default: begin
        // wait for press; stray codes fall back here
        if (pressed) begin
          press_start_d = now_i;
          phase_d       = PH_DEB_PR;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      press_start_q <= '0;
      last_event_q  <= '0;
      first_click_q <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      press_start_q <= press_start_d;
      last_event_q  <= last_event_d;
      first_click_q <= first_click_d;
    end
  end

  assign ev_o                 = ev;
  assign status_o.phase       = phase_q;
  assign status_o.first_click = first_click_q;

endmodule
